FILE: sv/aoc_pkg.sv
package aoc_pkg;

   localparam int COORD_BITS_DEF = 12;
   localparam int CFG_W          = 13;
   localparam int COL_W          = 8;
   localparam int CH_NUM         = 3;
   localparam int DEN_W          = 16;
   localparam int NUM_W          = 24;
   localparam int WGT_W          = 9;
   localparam int CSR_IDX_W      = 2;

   localparam logic [CSR_IDX_W-1:0] REG_OFFSET_X     = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_OFFSET_Y     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_FRONT_WIDTH  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] REG_FRONT_HEIGHT = 2'd3;

   localparam logic [WGT_W-1:0] ALPHA_ONE = 9'd256;

   typedef struct packed {
      logic signed [CFG_W-1:0] offset_x;
      logic signed [CFG_W-1:0] offset_y;
      logic [CFG_W-1:0]        front_width;
      logic [CFG_W-1:0]        front_height;
   } cfg_type;

   typedef struct packed {
      logic [CH_NUM-1:0][DEN_W-1:0] pf;
      logic [CH_NUM-1:0][DEN_W-1:0] pb;
      logic [WGT_W-1:0]             weight;
      logic [DEN_W-1:0]             den;
      logic [CH_NUM-1:0][COL_W-1:0] back_col;
      logic [COL_W-1:0]             back_alpha;
      logic                         covered;
      logic                         frame_end;
   } prep_type;

   typedef struct packed {
      logic [CH_NUM-1:0][NUM_W-1:0] rem;
      logic [CH_NUM-1:0][COL_W-1:0] quo;
      logic [DEN_W-1:0]             den;
      logic [COL_W-1:0]             alpha;
      logic                         covered;
      logic                         frame_end;
   } div_type;

endpackage

FILE: sv/aoc_if.sv
interface aoc_req_if #(parameter int COORD_BITS = aoc_pkg::COORD_BITS_DEF);
   import aoc_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [COORD_BITS-1:0] pixel_x;
   logic [COORD_BITS-1:0] pixel_y;
   logic [COL_W-1:0]      back_red;
   logic [COL_W-1:0]      back_green;
   logic [COL_W-1:0]      back_blue;
   logic [COL_W-1:0]      back_alpha;
   logic [COL_W-1:0]      front_red;
   logic [COL_W-1:0]      front_green;
   logic [COL_W-1:0]      front_blue;
   logic [COL_W-1:0]      front_alpha;
   logic                  frame_end;

   modport source (output valid, pixel_x, pixel_y, back_red, back_green, back_blue,
                   back_alpha, front_red, front_green, front_blue, front_alpha,
                   frame_end, input ready);
   modport sink (input valid, pixel_x, pixel_y, back_red, back_green, back_blue,
                 back_alpha, front_red, front_green, front_blue, front_alpha,
                 frame_end, output ready);
endinterface

interface aoc_rsp_if;
   import aoc_pkg::*;
   logic             valid;
   logic             ready;
   logic [COL_W-1:0] out_red;
   logic [COL_W-1:0] out_green;
   logic [COL_W-1:0] out_blue;
   logic [COL_W-1:0] out_alpha;
   logic             covered;
   logic             frame_end_out;

   modport source (output valid, out_red, out_green, out_blue, out_alpha, covered,
                   frame_end_out, input ready);
   modport sink (input valid, out_red, out_green, out_blue, out_alpha, covered,
                 frame_end_out, output ready);
endinterface

interface aoc_csr_if;
   import aoc_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [CFG_W-1:0]     data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

FILE: sv/alpha_over_composite.sv
// alpha-over compositing of a front image onto a back image, one back pixel per transfer
// req: pixel coordinates, back rgba and the front rgba that lands on this pixel
// rsp: composited rgba, covered flag and the frame_end marker of the same pixel
// csr: register writes (offset_x, offset_y, front_width, front_height), always ready;
//   write only while no pixel is in flight
// pipeline: one cell for the coverage test and alpha products, one for the
//   numerators, then eight divider cells, each resolving one quotient bit
//   for all three colours
// latency: 10 cycles from req transfer to rsp valid
// throughput: one pixel per cycle, set by the ten-cell chain with a register per cell
// every cell holds its item while the next one is full, so a stalled rsp
//   fills the empty cells first and req stays ready until the chain is full
// reset clears all valid bits and the four registers to zero, so no pixel
//   is covered until front_width and front_height are written
module alpha_over_composite #(
   parameter int COORD_BITS = aoc_pkg::COORD_BITS_DEF
) (
   input logic       clock,
   input logic       reset,
   aoc_req_if.sink   req,
   aoc_rsp_if.source rsp,
   aoc_csr_if.sink   csr
);
   import aoc_pkg::*;

   localparam int DIV_CELLS = COL_W;

   cfg_type  cfg_ff;
   cfg_type  cfg_in;
   logic     prep_valid;
   prep_type prep_data;
   logic     num_ready;
   logic     stage_valid [DIV_CELLS+1];
   div_type  stage_data  [DIV_CELLS+1];
   logic     stage_ready [DIV_CELLS+1];

   // configuration registers
   assign csr.ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr.valid) begin
         case (csr.index)
            REG_OFFSET_X: begin
               cfg_in.offset_x = signed'(csr.data);
            end
            REG_OFFSET_Y: begin
               cfg_in.offset_y = signed'(csr.data);
            end
            REG_FRONT_WIDTH: begin
               cfg_in.front_width = csr.data;
            end
            REG_FRONT_HEIGHT: begin
               cfg_in.front_height = csr.data;
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   aoc_prep_cell #(.COORD_BITS(COORD_BITS)) u_prep (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .req        (req),
      .down_ready (num_ready),
      .valid_o    (prep_valid),
      .data_o     (prep_data)
   );

   aoc_num_cell u_num (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (prep_valid),
      .in_data    (prep_data),
      .ready_o    (num_ready),
      .down_ready (stage_ready[0]),
      .valid_o    (stage_valid[0]),
      .data_o     (stage_data[0])
   );

   for (genvar k = 0; k < DIV_CELLS; k++) begin : g_div
      aoc_div_cell #(.BIT(DIV_CELLS - 1 - k)) u_div (
         .clock      (clock),
         .reset      (reset),
         .in_valid   (stage_valid[k]),
         .in_data    (stage_data[k]),
         .ready_o    (stage_ready[k]),
         .down_ready (stage_ready[k+1]),
         .valid_o    (stage_valid[k+1]),
         .data_o     (stage_data[k+1])
      );
   end

   assign stage_ready[DIV_CELLS] = rsp.ready;

   assign rsp.valid         = stage_valid[DIV_CELLS];
   assign rsp.out_red       = stage_data[DIV_CELLS].quo[0];
   assign rsp.out_green     = stage_data[DIV_CELLS].quo[1];
   assign rsp.out_blue      = stage_data[DIV_CELLS].quo[2];
   assign rsp.out_alpha     = stage_data[DIV_CELLS].alpha;
   assign rsp.covered       = stage_data[DIV_CELLS].covered;
   assign rsp.frame_end_out = stage_data[DIV_CELLS].frame_end;

`ifndef SYNTHESIS
   a_req_enters: assert property (@(posedge clock) disable iff (reset)
      req.valid && req.ready |=> prep_valid)
      else $error("accepted pixel did not enter the first cell");

   a_clear_black: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.covered && rsp.out_alpha == '0 |->
         rsp.out_red == '0 && rsp.out_green == '0 && rsp.out_blue == '0)
      else $error("transparent covered pixel has colour");
`endif

endmodule

FILE: sv/aoc_prep_cell.sv
module aoc_prep_cell #(
   parameter int COORD_BITS = aoc_pkg::COORD_BITS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  aoc_pkg::cfg_type  cfg,
   aoc_req_if.sink           req,
   input  logic              down_ready,
   output logic              valid_o,
   output aoc_pkg::prep_type data_o
);
   import aoc_pkg::*;

   localparam int DIFF_W = ((COORD_BITS > CFG_W) ? COORD_BITS : CFG_W) + 2;

   logic signed [DIFF_W-1:0]     fx;
   logic signed [DIFF_W-1:0]     fy;
   logic signed [DIFF_W-1:0]     fw;
   logic signed [DIFF_W-1:0]     fh;
   logic [CH_NUM-1:0][COL_W-1:0] front_col;
   logic [CH_NUM-1:0][COL_W-1:0] back_col;
   logic [DEN_W:0]               aw;
   logic                         ready;
   logic                         valid_ff;
   logic                         valid_in;
   prep_type                     data_ff;
   prep_type                     data_in;

   assign front_col = {req.front_blue, req.front_green, req.front_red};
   assign back_col  = {req.back_blue, req.back_green, req.back_red};

   always_comb begin
      fx = DIFF_W'($signed({1'b0, req.pixel_x})) - DIFF_W'(cfg.offset_x);
      fy = DIFF_W'($signed({1'b0, req.pixel_y})) - DIFF_W'(cfg.offset_y);
      fw = DIFF_W'($signed({1'b0, cfg.front_width}));
      fh = DIFF_W'($signed({1'b0, cfg.front_height}));
      data_in.weight     = ALPHA_ONE - WGT_W'(req.front_alpha);
      aw                 = (DEN_W + 1)'(req.back_alpha) * (DEN_W + 1)'(data_in.weight);
      data_in.den        = DEN_W'((DEN_W + 1)'({req.front_alpha, 8'h00}) + aw);
      data_in.back_col   = back_col;
      data_in.back_alpha = req.back_alpha;
      data_in.frame_end  = req.frame_end;
      data_in.covered    = !fx[DIFF_W-1] && !fy[DIFF_W-1] && (fx < fw) && (fy < fh);
      for (int c = 0; c < CH_NUM; c++) begin
         data_in.pf[c] = DEN_W'(front_col[c]) * DEN_W'(req.front_alpha);
         data_in.pb[c] = DEN_W'(back_col[c]) * DEN_W'(req.back_alpha);
      end
   end

   assign ready     = !valid_ff || down_ready;
   assign req.ready = ready;
   assign valid_in  = ready ? req.valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req.valid && ready) begin
         data_ff <= data_in;
      end
   end

   assign valid_o = valid_ff;
   assign data_o  = data_ff;

endmodule

FILE: sv/aoc_num_cell.sv
module aoc_num_cell (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  aoc_pkg::prep_type in_data,
   output logic              ready_o,
   input  logic              down_ready,
   output logic              valid_o,
   output aoc_pkg::div_type  data_o
);
   import aoc_pkg::*;

   logic [CH_NUM-1:0][NUM_W:0]   mul;
   logic [CH_NUM-1:0][NUM_W-1:0] num;
   logic                         zero_den;
   logic                         valid_ff;
   logic                         valid_in;
   div_type                      data_ff;
   div_type                      data_in;

   always_comb begin
      zero_den          = (in_data.den == '0);
      data_in.quo       = '0;
      data_in.covered   = in_data.covered;
      data_in.frame_end = in_data.frame_end;
      for (int c = 0; c < CH_NUM; c++) begin
         mul[c] = (NUM_W + 1)'(in_data.pb[c]) * (NUM_W + 1)'(in_data.weight);
         num[c] = NUM_W'({in_data.pf[c], 8'h00}) + NUM_W'(mul[c]);
      end
      if (!in_data.covered) begin
         // divide back colour by one to pass it through
         data_in.den   = DEN_W'(1);
         data_in.alpha = in_data.back_alpha;
         for (int c = 0; c < CH_NUM; c++) begin
            data_in.rem[c] = NUM_W'(in_data.back_col[c]);
         end
      end else if (zero_den) begin
         data_in.den   = DEN_W'(1);
         data_in.alpha = '0;
         data_in.rem   = '0;
      end else begin
         data_in.den   = in_data.den;
         data_in.alpha = in_data.den[DEN_W-1:DEN_W-COL_W];
         data_in.rem   = num;
      end
   end

   assign ready_o  = !valid_ff || down_ready;
   assign valid_in = ready_o ? in_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && ready_o) begin
         data_ff <= data_in;
      end
   end

   assign valid_o = valid_ff;
   assign data_o  = data_ff;

`ifndef SYNTHESIS
   a_den_nonzero: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> data_ff.den != '0)
      else $error("divisor of zero entered divider chain");
`endif

endmodule

FILE: sv/aoc_div_cell.sv
module aoc_div_cell #(
   parameter int BIT = 0
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   input  aoc_pkg::div_type in_data,
   output logic             ready_o,
   input  logic             down_ready,
   output logic             valid_o,
   output aoc_pkg::div_type data_o
);
   import aoc_pkg::*;

   logic [NUM_W-1:0] shifted;
   logic             valid_ff;
   logic             valid_in;
   div_type          data_ff;
   div_type          data_in;

   assign shifted = NUM_W'(in_data.den) << BIT;

   always_comb begin
      data_in = in_data;
      for (int c = 0; c < CH_NUM; c++) begin
         if (in_data.rem[c] >= shifted) begin
            data_in.rem[c]      = in_data.rem[c] - shifted;
            data_in.quo[c][BIT] = 1'b1;
         end
      end
   end

   assign ready_o  = !valid_ff || down_ready;
   assign valid_in = ready_o ? in_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && ready_o) begin
         data_ff <= data_in;
      end
   end

   assign valid_o = valid_ff;
   assign data_o  = data_ff;

`ifndef SYNTHESIS
   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> (data_ff.rem[0] < (NUM_W'(data_ff.den) << BIT)) &&
                   (data_ff.rem[1] < (NUM_W'(data_ff.den) << BIT)) &&
                   (data_ff.rem[2] < (NUM_W'(data_ff.den) << BIT)))
      else $error("partial remainder out of range");
`endif

endmodule
